// File: design/stalta_pkg.sv
// ----------------------------------------------------------------------------
// stalta_pkg
// Shared types, widths and reset values for the STA/LTA seismic trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package stalta_pkg;

   localparam int DEF_MAX_LONG_WINDOW = 1024;
   localparam int DEF_SAMPLE_BITS     = 16;

   localparam int LEN_W   = 11;
   localparam int THR_W   = 8;
   localparam int ACC_W   = 15;
   localparam int RATIO_W = 20;
   localparam int FRAC_W  = 8;
   localparam int INT_W   = RATIO_W - FRAC_W;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [LEN_W-1:0] LONG_LEN_RST  = 11'd1024;
   localparam logic [LEN_W-1:0] SHORT_LEN_RST = 11'd64;
   localparam logic [THR_W-1:0] RATIO_THR_RST = 8'd4;
   localparam logic [ACC_W-1:0] ACCEL_THR_RST = 15'd16384;

   typedef enum logic [1:0] {
      REG_LONG_LEN  = 2'd0,
      REG_SHORT_LEN = 2'd1,
      REG_RATIO_THR = 2'd2,
      REG_ACCEL_THR = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      EVENT_NONE  = 2'd0,
      EVENT_ACCEL = 2'd1,
      EVENT_RATIO = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_RATIO,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_SAT,
      DV_DIV,
      DV_DONE
   } div_state_type;

   typedef struct packed {
      logic [LEN_W-1:0] long_len;
      logic [LEN_W-1:0] short_len;
      logic [THR_W-1:0] ratio_thr;
      logic [ACC_W-1:0] accel_thr;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic update;
      logic clear;
   } hist_ctl_type;

   typedef struct packed {
      logic done;
      logic trig;
   } ratio_stat_type;

endpackage

`default_nettype wire

// File: design/stalta_if.sv
// ----------------------------------------------------------------------------
// stalta_if
// Valid/ready channels for sample words in and trigger words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stalta_req_if
   import stalta_pkg::*;
   #(parameter int SAMPLE_BITS = DEF_SAMPLE_BITS)
   ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          on_ground;

   modport source (output valid, output sample, output on_ground, input ready);
   modport sink   (input valid, input sample, input on_ground, output ready);
endinterface

interface stalta_rsp_if
   import stalta_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         event_res;
   logic [RATIO_W-1:0] ratio;

   modport source (output valid, output event_res, output ratio, input ready);
   modport sink   (input valid, input event_res, input ratio, output ready);
endinterface

`default_nettype wire

// File: design/stalta_csr.sv
// ----------------------------------------------------------------------------
// stalta_csr
// Configuration registers behind an APB-style port; flags window restarts.
// ----------------------------------------------------------------------------
`default_nettype none

module stalta_csr
   import stalta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg,
   output      logic                  win_clear
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in    = cfg_ff;
      win_clear = 1'b0;
      if (wr_en) begin
         case (reg_idx)
            REG_LONG_LEN: begin
               cfg_in.long_len = csr_pwdata[LEN_W-1:0];
               win_clear       = 1'b1;
            end
            REG_SHORT_LEN: begin
               cfg_in.short_len = csr_pwdata[LEN_W-1:0];
               win_clear        = 1'b1;
            end
            REG_RATIO_THR: begin
               cfg_in.ratio_thr = csr_pwdata[THR_W-1:0];
            end
            REG_ACCEL_THR: begin
               cfg_in.accel_thr = csr_pwdata[ACC_W-1:0];
               win_clear        = 1'b1;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_len  <= LONG_LEN_RST;
         cfg_ff.short_len <= SHORT_LEN_RST;
         cfg_ff.ratio_thr <= RATIO_THR_RST;
         cfg_ff.accel_thr <= ACCEL_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LONG_LEN:  csr_prdata = CSR_DATA_W'(cfg_ff.long_len);
         REG_SHORT_LEN: csr_prdata = CSR_DATA_W'(cfg_ff.short_len);
         REG_RATIO_THR: csr_prdata = CSR_DATA_W'(cfg_ff.ratio_thr);
         REG_ACCEL_THR: csr_prdata = CSR_DATA_W'(cfg_ff.accel_thr);
         default:       csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: design/stalta_hist.sv
// ----------------------------------------------------------------------------
// stalta_hist
// Sample delay line in one memory plus the running window sums and the
// count of strong samples, updated by read-modify-write per word.
// ----------------------------------------------------------------------------
`default_nettype none

module stalta_hist
   import stalta_pkg::*;
#(
   parameter  int MAX_LONG_WINDOW = DEF_MAX_LONG_WINDOW,
   parameter  int SAMPLE_BITS     = DEF_SAMPLE_BITS,
   localparam int AW    = $clog2(MAX_LONG_WINDOW),
   localparam int CNT_W = $clog2(MAX_LONG_WINDOW + 1),
   localparam int SUM_W = SAMPLE_BITS - 1 + CNT_W,
   localparam int IW    = ((AW > LEN_W) ? AW : LEN_W) + 1,
   localparam int CMP_W = (SAMPLE_BITS > ACC_W) ? SAMPLE_BITS : ACC_W
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hist_ctl_type           ctl,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [LEN_W-1:0]       len_l,
   input  wire logic [LEN_W-1:0]       len_s,
   input  wire logic [ACC_W-1:0]       accel_thr,
   output      logic [SUM_W-1:0]       long_sum,
   output      logic [SUM_W-1:0]       short_sum,
   output      logic                   exceed_hit
);

   logic [SAMPLE_BITS-1:0] hist_mem [MAX_LONG_WINDOW];

   logic [AW-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       exc_ff, exc_in;
   logic [SUM_W-1:0]       long_ff, long_in;
   logic [SUM_W-1:0]       short_ff, short_in;

   logic [SAMPLE_BITS-1:0] smp_ff;
   logic [SAMPLE_BITS-1:0] old_l_ff;
   logic [SAMPLE_BITS-1:0] old_s_ff;
   logic                   vld_l_ff;
   logic                   vld_s_ff;

   logic [IW-1:0]          pos_x;
   logic [IW-1:0]          idx_l_x;
   logic [IW-1:0]          idx_s_x;
   logic [SAMPLE_BITS-1:0] mag_new;
   logic [SAMPLE_BITS-1:0] mag_old_l;
   logic [SAMPLE_BITS-1:0] mag_old_s;
   logic                   new_big;
   logic                   old_big;

   function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] raw);
      // most negative code maps onto 2^(n-1), which still fits unsigned
      return raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
   endfunction

   // oldest entries of each window, modulo the line length
   always_comb begin
      pos_x   = IW'(pos_ff);
      idx_l_x = (pos_x >= IW'(len_l)) ? (pos_x - IW'(len_l))
                                      : (pos_x + IW'(MAX_LONG_WINDOW) - IW'(len_l));
      idx_s_x = (pos_x >= IW'(len_s)) ? (pos_x - IW'(len_s))
                                      : (pos_x + IW'(MAX_LONG_WINDOW) - IW'(len_s));
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         old_l_ff <= hist_mem[idx_l_x[AW-1:0]];
         old_s_ff <= hist_mem[idx_s_x[AW-1:0]];
         smp_ff   <= sample;
         // entries beyond the fill count hold no current sample and count as zero
         vld_l_ff <= IW'(len_l) <= IW'(fill_ff);
         vld_s_ff <= IW'(len_s) <= IW'(fill_ff);
      end
      if (ctl.update) begin
         hist_mem[pos_ff] <= smp_ff;
      end
   end

   always_comb begin
      mag_new   = mag_of(smp_ff);
      mag_old_l = vld_l_ff ? mag_of(old_l_ff) : '0;
      mag_old_s = vld_s_ff ? mag_of(old_s_ff) : '0;
      new_big   = CMP_W'(mag_new) > CMP_W'(accel_thr);
      old_big   = CMP_W'(mag_old_l) > CMP_W'(accel_thr);

      long_in  = long_ff + SUM_W'(mag_new) - SUM_W'(mag_old_l);
      short_in = short_ff + SUM_W'(mag_new) - SUM_W'(mag_old_s);
      exc_in   = exc_ff + CNT_W'(new_big) - CNT_W'(old_big);
      pos_in   = (pos_ff == AW'(MAX_LONG_WINDOW - 1)) ? '0 : pos_ff + AW'(1);
      fill_in  = (fill_ff == CNT_W'(MAX_LONG_WINDOW)) ? fill_ff : fill_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         long_ff  <= '0;
         short_ff <= '0;
         exc_ff   <= '0;
         pos_ff   <= '0;
         fill_ff  <= '0;
      end else if (ctl.update) begin
         long_ff  <= long_in;
         short_ff <= short_in;
         exc_ff   <= exc_in;
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
      end
   end

   assign long_sum   = long_ff;
   assign short_sum  = short_ff;
   assign exceed_hit = exc_ff != '0;

endmodule

`default_nettype wire

// File: design/stalta_ratio.sv
// ----------------------------------------------------------------------------
// stalta_ratio
// Cross products of the window sums, then a radix-2 restoring divider that
// yields the saturated Q12.8 ratio and the exact threshold decision.
// ----------------------------------------------------------------------------
`default_nettype none

module stalta_ratio
   import stalta_pkg::*;
#(
   parameter  int SUM_W  = 26,
   localparam int PROD_W = SUM_W + LEN_W,
   localparam int CNT_W  = $clog2(RATIO_W)
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   long_sum,
   input  wire logic [SUM_W-1:0]   short_sum,
   input  wire logic [LEN_W-1:0]   len_l,
   input  wire logic [LEN_W-1:0]   len_s,
   input  wire logic [THR_W-1:0]   ratio_thr,
   output      logic [RATIO_W-1:0] ratio,
   output      ratio_stat_type     stat
);

   div_state_type      dv_state_ff, dv_state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [PROD_W-1:0]  num_ff;
   logic [PROD_W-1:0]  den_ff;
   logic [THR_W-1:0]   thr_ff;
   logic               sat_ff;
   logic               zero_ff;
   logic [PROD_W-1:0]  rem_ff;
   logic [RATIO_W-1:0] quo_ff;
   logic [RATIO_W-1:0] bits_ff;

   logic [PROD_W-1:0]  num_in;
   logic [PROD_W-1:0]  den_in;
   logic [PROD_W:0]    trial;
   logic [PROD_W:0]    diff;
   logic               ge;
   logic [RATIO_W-1:0] thr_q;

   assign num_in = PROD_W'(short_sum) * PROD_W'(len_l);
   assign den_in = PROD_W'(long_sum) * PROD_W'(len_s);

   // one quotient bit per cycle; remainder stays below the divisor unless the quotient saturates
   assign trial = {rem_ff, bits_ff[RATIO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_state_ff <= DV_IDLE;
         cnt_ff      <= '0;
      end else begin
         dv_state_ff <= dv_state_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_comb begin
      dv_state_in = dv_state_ff;
      cnt_in      = cnt_ff;
      case (dv_state_ff)
         DV_IDLE: begin
            if (start) begin
               dv_state_in = DV_SAT;
            end
         end
         DV_SAT: begin
            cnt_in      = '0;
            dv_state_in = DV_DIV;
         end
         DV_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RATIO_W - 1)) begin
               dv_state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            dv_state_in = DV_IDLE;
         end
         default: begin
            dv_state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (dv_state_ff)
         DV_IDLE: begin
            if (start) begin
               num_ff <= num_in;
               den_ff <= den_in;
               thr_ff <= ratio_thr;
            end
         end
         DV_SAT: begin
            // quotient would need more than the integer bits: clip
            sat_ff  <= (PROD_W + INT_W)'(num_ff) >= {den_ff, {INT_W{1'b0}}};
            zero_ff <= den_ff == '0;
            rem_ff  <= num_ff >> INT_W;
            bits_ff <= {num_ff[INT_W-1:0], {FRAC_W{1'b0}}};
         end
         DV_DIV: begin
            rem_ff  <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
            quo_ff  <= {quo_ff[RATIO_W-2:0], ge};
            bits_ff <= {bits_ff[RATIO_W-2:0], 1'b0};
         end
         default: begin
         end
      endcase
   end

   assign thr_q = RATIO_W'({thr_ff, {FRAC_W{1'b0}}});

   always_comb begin
      if (zero_ff) begin
         ratio = '0;
      end else if (sat_ff) begin
         ratio = '1;
      end else begin
         ratio = quo_ff;
      end
      stat.done = dv_state_ff == DV_DONE;
      // exact compare: a remainder left over at equality still means "above"
      stat.trig = !zero_ff &&
                  (sat_ff || (quo_ff > thr_q) || ((quo_ff == thr_q) && (rem_ff != '0)));
   end

endmodule

`default_nettype wire

// File: design/sta_lta_seismic_trigger_core.sv
// ----------------------------------------------------------------------------
// sta_lta_seismic_trigger_core
// STA/LTA seismic trigger: one trigger word out for each sample word in.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a signed sample and the on-ground flag; rsp returns the event
//   code and the short/long average ratio in unsigned Q12.8.
//   Configuration goes through the csr_ APB-style port (window lengths,
//   ratio threshold, acceleration threshold); it must be written only while
//   the block is idle, and the block itself does not enforce this.
//   Writing a window length or the acceleration threshold restarts the
//   window at once: no memory sweep is needed, a fill count marks which
//   delay-line entries hold real samples.
//   Each sample passes in order through memory read, window update, cross
//   products, saturation check and the 20-step restoring divider that
//   forms the ratio; the result word then goes to the output register.
//   One word is worked on at a time. The result sits in an output register,
//   so the next sample is taken while an earlier result is still held by a
//   stalled receiver; a finished result then waits until rsp frees.
//   Reset (synchronous, active high) restores the register defaults and
//   empties the window; the block is ready in the first cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_lta_seismic_trigger_core
   import stalta_pkg::*;
#(
   parameter int MAX_LONG_WINDOW = DEF_MAX_LONG_WINDOW,
   parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   stalta_req_if.sink                 req,
   stalta_rsp_if.source               rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_LONG_WINDOW + 1);
   localparam int SUM_W = SAMPLE_BITS - 1 + CNT_W;

   state_type          state_ff, state_in;
   cfg_type            cfg;
   logic               win_clear;
   hist_ctl_type       hist_ctl;
   ratio_stat_type     ratio_stat;
   logic [LEN_W-1:0]   len_l;
   logic [LEN_W-1:0]   len_s;
   logic [LEN_W-1:0]   s_tmp;
   logic [SUM_W-1:0]   long_sum;
   logic [SUM_W-1:0]   short_sum;
   logic               exceed_hit;
   logic [RATIO_W-1:0] ratio_val;
   logic               ratio_start;
   logic               accept;
   logic               out_free;
   logic               out_load;
   event_type          event_val;

   logic               on_ground_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   event_type          rsp_event_ff;
   logic [RATIO_W-1:0] rsp_ratio_ff;

   stalta_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .win_clear   (win_clear)
   );

   // window clamping: long to [2, max], short to [1, long]
   always_comb begin
      if (cfg.long_len < LEN_W'(2)) begin
         len_l = LEN_W'(2);
      end else if (32'(cfg.long_len) > 32'(MAX_LONG_WINDOW)) begin
         len_l = LEN_W'(MAX_LONG_WINDOW);
      end else begin
         len_l = cfg.long_len;
      end
      s_tmp = (cfg.short_len == '0) ? LEN_W'(1) : cfg.short_len;
      len_s = (s_tmp > len_l) ? len_l : s_tmp;
   end

   stalta_hist #(
      .MAX_LONG_WINDOW (MAX_LONG_WINDOW),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .ctl        (hist_ctl),
      .sample     (req.sample),
      .len_l      (len_l),
      .len_s      (len_s),
      .accel_thr  (cfg.accel_thr),
      .long_sum   (long_sum),
      .short_sum  (short_sum),
      .exceed_hit (exceed_hit)
   );

   stalta_ratio #(
      .SUM_W (SUM_W)
   ) u_ratio (
      .clock     (clock),
      .reset     (reset),
      .start     (ratio_start),
      .long_sum  (long_sum),
      .short_sum (short_sum),
      .len_l     (len_l),
      .len_s     (len_s),
      .ratio_thr (cfg.ratio_thr),
      .ratio     (ratio_val),
      .stat      (ratio_stat)
   );

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req.ready       = 1'b0;
      hist_ctl.load   = 1'b0;
      hist_ctl.update = 1'b0;
      hist_ctl.clear  = win_clear;
      ratio_start     = 1'b0;
      out_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready     = 1'b1;
            hist_ctl.load = req.valid;
            if (req.valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            hist_ctl.update = 1'b1;
            state_in        = ST_START;
         end
         ST_START: begin
            ratio_start = 1'b1;
            state_in    = ST_RATIO;
         end
         ST_RATIO: begin
            if (ratio_stat.done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            out_load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         on_ground_ff <= req.on_ground;
      end
   end

   always_comb begin
      if (ratio_stat.trig) begin
         event_val = EVENT_RATIO;
      end else if (on_ground_ff && exceed_hit) begin
         event_val = EVENT_ACCEL;
      end else begin
         event_val = EVENT_NONE;
      end
   end

   // output register: holds the word while the receiver stalls
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_event_ff <= event_val;
         rsp_ratio_ff <= ratio_val;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.event_res = rsp_event_ff;
   assign rsp.ratio     = rsp_ratio_ff;

endmodule

`default_nettype wire

// File: design/stalta_checker.sv
// ----------------------------------------------------------------------------
// stalta_checker
// Port-level checks of the trigger core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stalta_checker
   import stalta_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_event_res,
   input wire logic [RATIO_W-1:0] rsp_ratio,
   input wire logic               csr_pready
);

   // reset leaves no result word pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one word at a time: no back-to-back acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while previous word still in work");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_event_res) && $stable(rsp_ratio))
      else $error("result word changed while stalled");

   a_pready_high: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("configuration port inserted wait state");

endmodule

bind sta_lta_seismic_trigger_core stalta_checker u_stalta_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_event_res (rsp.event_res),
   .rsp_ratio     (rsp.ratio),
   .csr_pready    (csr_pready)
);

`default_nettype wire
